// File: rtl/sbbd_pkg.sv
`default_nettype none

package sbbd_pkg;

  localparam int unsigned RamBytes  = 65536;
  localparam int unsigned FifoDepth = 32;
  localparam int unsigned RamAw     = $clog2(RamBytes);
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Item command codes
  localparam logic [1:0] CmdBusRead  = 2'd0;
  localparam logic [1:0] CmdBusWrite = 2'd1;
  localparam logic [1:0] CmdHostCmd  = 2'd2;
  localparam logic [1:0] CmdSample   = 2'd3;

  // Decode target codes
  localparam logic [3:0] TgtNone   = 4'd0;
  localparam logic [3:0] TgtProg   = 4'd1;
  localparam logic [3:0] TgtRam    = 4'd2;
  localparam logic [3:0] TgtFifo   = 4'd3;
  localparam logic [3:0] TgtFm     = 4'd4;
  localparam logic [3:0] TgtPcm0   = 4'd5;
  localparam logic [3:0] TgtPcm1   = 4'd6;
  localparam logic [3:0] TgtBank0  = 4'd7;
  localparam logic [3:0] TgtBank1  = 4'd8;
  localparam logic [3:0] TgtSample = 4'd9;

  // Configuration register indexes
  localparam logic CfgProgRomBytes   = 1'b0;
  localparam logic CfgSampleRomBytes = 1'b1;

  localparam logic [19:0] ProgRomBytesRst   = 20'h80000;
  localparam logic [23:0] SampleRomBytesRst = 24'h800000;

  // Address map
  localparam logic [23:0] FifoPopAddr  = 24'hc20001;
  localparam logic [23:0] Bank0Addr    = 24'hc50001;
  localparam logic [23:0] Bank1Addr    = 24'hc70001;
  localparam logic [19:0] ProgMirrorDelta = 20'h60000;
  localparam logic [23:0] RamBase      = 24'hf00000;
  localparam logic [23:0] FmBase       = 24'hd00000;
  localparam logic [23:0] Pcm0Base     = 24'hc40000;
  localparam logic [23:0] Pcm1Base     = 24'hc60000;
  localparam logic [7:0]  OpenBusByte  = 8'hff;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: rtl/sound_board_bus_decoder_fifo_unit.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   cmd_i bus_address_i data_byte_i pcm_chip_i
//                                               sample_address_i
// out      output     out_valid_o / out_stall_i target_o offset_o read_data_o out_of_range_o
//                                               chip_write_o data_out_o irq_level_o
// cfg      input      cfg_we_i                  cfg_index_i cfg_data_i
//
// An item has a capture step, which latches it and reads work RAM and the FIFO head,
// then an execute step, which decodes, updates state and loads the result register.
// The execute cycle waits while the result register holds a word that is stalled.
// After reset, work RAM is zeroed one byte per cycle (all RamBytes bytes, 65536 by
// default); in_stall_o stays high until that pass ends. Config writes are taken anytime.
`default_nettype none

module sound_board_bus_decoder_fifo_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  cmd_i,
  input  wire  [23:0] bus_address_i,
  input  wire  [7:0]  data_byte_i,
  input  wire         pcm_chip_i,
  input  wire  [21:0] sample_address_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [3:0]  target_o,
  output logic [22:0] offset_o,
  output logic [7:0]  read_data_o,
  output logic        out_of_range_o,
  output logic        chip_write_o,
  output logic [7:0]  data_out_o,
  output logic [2:0]  irq_level_o,
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire  [23:0] cfg_data_i
);

  sbbd_pkg::ctrl_cmd_t ctrl_cmd;
  logic                clr_done;

  sbbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .clr_done_i  (clr_done),
    .cmd_o       (ctrl_cmd)
  );

  sbbd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .clr_done_o       (clr_done),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_in_i         (cmd_i),
    .bus_address_i    (bus_address_i),
    .data_byte_i      (data_byte_i),
    .pcm_chip_i       (pcm_chip_i),
    .sample_address_i (sample_address_i),
    .target_o         (target_o),
    .offset_o         (offset_o),
    .read_data_o      (read_data_o),
    .out_of_range_o   (out_of_range_o),
    .chip_write_o     (chip_write_o),
    .data_out_o       (data_out_o),
    .irq_level_o      (irq_level_o)
  );

endmodule

`default_nettype wire

// File: rtl/sbbd_ctrl.sv
`default_nettype none

module sbbd_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  wire                 clr_done_i,
  output sbbd_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   exec_go;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == StIdle);
  // result register frees up in the same cycle it is taken
  assign exec_go     = (state_q == StExec) && (!out_valid_q || !out_stall_i);

  assign cmd_o.clr_step = (state_q == StClear);
  assign cmd_o.capture  = accept;
  assign cmd_o.execute  = exec_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StClear: if (clr_done_i) state_q <= StIdle;
        StIdle:  if (accept) state_q <= StExec;
        StExec:  if (exec_go) state_q <= StIdle;
        default: state_q <= StClear;
      endcase
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbbd_datapath.sv
`default_nettype none

module sbbd_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sbbd_pkg::ctrl_cmd_t cmd_i,
  output logic                clr_done_o,
  input  wire                 cfg_we_i,
  input  wire                 cfg_index_i,
  input  wire  [23:0]         cfg_data_i,
  input  wire  [1:0]          cmd_in_i,
  input  wire  [23:0]         bus_address_i,
  input  wire  [7:0]          data_byte_i,
  input  wire                 pcm_chip_i,
  input  wire  [21:0]         sample_address_i,
  output logic [3:0]          target_o,
  output logic [22:0]         offset_o,
  output logic [7:0]          read_data_o,
  output logic                out_of_range_o,
  output logic                chip_write_o,
  output logic [7:0]          data_out_o,
  output logic [2:0]          irq_level_o
);

  localparam int unsigned RamAw  = sbbd_pkg::RamAw;
  localparam int unsigned FifoAw = sbbd_pkg::FifoAw;

  function automatic logic [FifoAw-1:0] ptr_next(input logic [FifoAw-1:0] p);
    logic [FifoAw-1:0] r;
    if (p == FifoAw'(sbbd_pkg::FifoDepth - 1)) r = '0;
    else r = p + FifoAw'(1);
    return r;
  endfunction

  logic [7:0] ram_mem  [sbbd_pkg::RamBytes];
  logic [7:0] fifo_mem [sbbd_pkg::FifoDepth];

  logic [RamAw-1:0]  clr_ctr_q;
  logic [7:0]        ram_rd_q;
  logic [7:0]        fifo_rd_q;
  logic [FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic              irq_q, irq_d;
  logic [1:0]        bank0_q, bank0_d;
  logic [1:0]        bank1_q, bank1_d;
  logic [19:0]       prog_bytes_q;
  logic [23:0]       sample_bytes_q;

  // latched item
  logic [1:0]  cmd_q;
  logic [23:0] addr_q;
  logic [7:0]  data_q;
  logic        chip_q;
  logic [21:0] saddr_q;

  // result
  logic [3:0]  tgt_d;
  logic [22:0] off_d;
  logic [7:0]  rdat_d;
  logic        oor_d;
  logic        cwr_d;
  logic [7:0]  dout_d;

  logic              ram_hit;
  logic              ram_we;
  logic              fifo_we;
  logic [19:0]       prog_off;
  logic [21:0]       samp_off;
  logic [22:0]       samp_full;
  logic [1:0]        samp_bank;
  logic [FifoAw-1:0] wr_nx;

  assign clr_done_o = (clr_ctr_q == RamAw'(sbbd_pkg::RamBytes - 1));

  assign ram_hit = (addr_q[23:20] == sbbd_pkg::RamBase[23:20]) &&
                   ({1'b0, addr_q[19:0]} < 21'(sbbd_pkg::RamBytes));
  assign prog_off = (addr_q[19] ? addr_q[19:0] - sbbd_pkg::ProgMirrorDelta
                                : addr_q[19:0]) ^ 20'h1;
  assign samp_bank = chip_q ? bank1_q : bank0_q;
  assign samp_off  = saddr_q[20] ? {samp_bank, saddr_q[19:0]} : {2'b00, saddr_q[19:0]};
  assign samp_full = {chip_q, samp_off};
  assign wr_nx     = ptr_next(wr_ptr_q);

  always_comb begin
    tgt_d    = sbbd_pkg::TgtNone;
    off_d    = '0;
    rdat_d   = '0;
    oor_d    = 1'b0;
    cwr_d    = 1'b0;
    dout_d   = '0;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    irq_d    = irq_q;
    bank0_d  = bank0_q;
    bank1_d  = bank1_q;
    ram_we   = 1'b0;
    fifo_we  = 1'b0;
    unique case (cmd_q)
      sbbd_pkg::CmdBusRead: begin
        if (addr_q[23:19] == 5'd0 || addr_q[23:17] == 7'b0000100) begin
          tgt_d = sbbd_pkg::TgtProg;
          off_d = 23'(prog_off);
          if (prog_off >= prog_bytes_q) begin
            rdat_d = sbbd_pkg::OpenBusByte;
            oor_d  = 1'b1;
          end
        end else if (ram_hit) begin
          tgt_d  = sbbd_pkg::TgtRam;
          off_d  = 23'(addr_q[19:0]);
          rdat_d = ram_rd_q;
        end else if (addr_q == sbbd_pkg::FifoPopAddr) begin
          tgt_d = sbbd_pkg::TgtFifo;
          if (rd_ptr_q != wr_ptr_q) begin
            rdat_d   = fifo_rd_q;
            rd_ptr_d = ptr_next(rd_ptr_q);
          end
          // drained by this pop, or already empty
          if (rd_ptr_d == wr_ptr_q) irq_d = 1'b0;
        end else if (addr_q[23:3] == sbbd_pkg::FmBase[23:3] && addr_q[0]) begin
          tgt_d = sbbd_pkg::TgtFm;
          off_d = 23'(addr_q[2:1]);
        end
      end
      sbbd_pkg::CmdBusWrite: begin
        if (ram_hit) begin
          tgt_d  = sbbd_pkg::TgtRam;
          off_d  = 23'(addr_q[19:0]);
          ram_we = 1'b1;
        end else if (addr_q[23:4] == sbbd_pkg::Pcm0Base[23:4]) begin
          if (addr_q[0]) begin
            tgt_d  = sbbd_pkg::TgtPcm0;
            off_d  = 23'(addr_q[2:1]);
            cwr_d  = 1'b1;
            dout_d = data_q;
          end
        end else if (addr_q[23:4] == sbbd_pkg::Pcm1Base[23:4]) begin
          if (addr_q[0]) begin
            tgt_d  = sbbd_pkg::TgtPcm1;
            off_d  = 23'(addr_q[2:1]);
            cwr_d  = 1'b1;
            dout_d = data_q;
          end
        end else if (addr_q == sbbd_pkg::Bank0Addr) begin
          tgt_d   = sbbd_pkg::TgtBank0;
          bank0_d = data_q[1:0];
        end else if (addr_q == sbbd_pkg::Bank1Addr) begin
          tgt_d   = sbbd_pkg::TgtBank1;
          bank1_d = data_q[1:0];
        end else if (addr_q[23:3] == sbbd_pkg::FmBase[23:3] && addr_q[0]) begin
          tgt_d  = sbbd_pkg::TgtFm;
          off_d  = 23'(addr_q[2:1]);
          cwr_d  = 1'b1;
          dout_d = data_q;
        end
      end
      sbbd_pkg::CmdHostCmd: begin
        // full FIFO drops the word but still raises the interrupt
        if (wr_nx != rd_ptr_q) begin
          fifo_we  = 1'b1;
          wr_ptr_d = wr_nx;
        end
        irq_d = 1'b1;
      end
      sbbd_pkg::CmdSample: begin
        tgt_d = sbbd_pkg::TgtSample;
        if (saddr_q[21]) begin
          oor_d = 1'b1;
        end else begin
          off_d = samp_full;
          oor_d = ({1'b0, samp_full} >= sample_bytes_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      ram_mem[clr_ctr_q] <= '0;
    end else if (cmd_i.execute && ram_we) begin
      ram_mem[addr_q[RamAw-1:0]] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ram_rd_q <= ram_mem[bus_address_i[RamAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && fifo_we) begin
      fifo_mem[wr_ptr_q] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fifo_rd_q <= fifo_mem[rd_ptr_q];
      cmd_q     <= cmd_in_i;
      addr_q    <= bus_address_i;
      data_q    <= data_byte_i;
      chip_q    <= pcm_chip_i;
      saddr_q   <= sample_address_i;
    end
    if (cmd_i.execute) begin
      target_o       <= tgt_d;
      offset_o       <= off_d;
      read_data_o    <= rdat_d;
      out_of_range_o <= oor_d;
      chip_write_o   <= cwr_d;
      data_out_o     <= dout_d;
      irq_level_o    <= irq_d ? 3'd2 : 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ctr_q      <= '0;
      rd_ptr_q       <= '0;
      wr_ptr_q       <= '0;
      irq_q          <= 1'b0;
      bank0_q        <= '0;
      bank1_q        <= '0;
      prog_bytes_q   <= sbbd_pkg::ProgRomBytesRst;
      sample_bytes_q <= sbbd_pkg::SampleRomBytesRst;
    end else begin
      if (cmd_i.clr_step && !clr_done_o) begin
        clr_ctr_q <= clr_ctr_q + RamAw'(1);
      end
      if (cmd_i.execute) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        irq_q    <= irq_d;
        bank0_q  <= bank0_d;
        bank1_q  <= bank1_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sbbd_pkg::CfgProgRomBytes:   prog_bytes_q   <= cfg_data_i[19:0];
          sbbd_pkg::CfgSampleRomBytes: sample_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
